@@ rtl/hcat_pkg.sv @@
package hcat_pkg;

    localparam int TableSlots = 1024;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOT_SET = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_PROBE,
        S_PWAIT,
        S_CHECK,
        S_RWAIT,
        S_RSLOT,
        S_RDATA,
        S_CLEAR,
        S_OUT
    } state_t;

    localparam logic [63:0] MixAdd = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MixM1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MixM2  = 64'h94D049BB133111EB;

endpackage

@@ rtl/hash_count_aggregation_table_top.sv @@
// Linear-probing aggregation table. One item in, one result out, one item in flight at a
// time; s_tready is high only while the block is idle. The steps from accepting an item to
// raising m_tvalid:
// - add: splitmix64 hashing in states S_H0 to S_H4 (each 64x64 multiply is split into 32-bit
//   partial products), then for each probed slot S_PROBE, S_PWAIT for the registered read of
//   the slot memory, and S_CHECK, then S_OUT to load the result.
// - add of a new key with no free slot: probes every slot and returns status 1.
// - read: S_RWAIT, S_RSLOT, S_RDATA, S_OUT; S_RWAIT, S_OUT if the position is not yet filled.
// - op 3: straight to S_OUT.
// - clear: sweeps the used-bit memory one slot per cycle in S_CLEAR, then S_OUT. The same
//   sweep runs after reset before the first item is accepted.
// The block returns to idle when the result is loaded. A result that is not taken does
// not stop the next item from being accepted; the next result waits in S_OUT and is loaded
// only after the previous one has been taken.
module hash_count_aggregation_table_top #(
    parameter int TABLE_SLOTS = hcat_pkg::TableSlots
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], key[65:2], amount[129:66], position[139:130], zero fill
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // key_out[63:0], total_out[127:64], distinct_out[138:128], status[140:139], zero fill
    output logic [143:0] m_tdata
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    logic [63:0] keys_mem [TABLE_SLOTS];
    logic [63:0] tots_mem [TABLE_SLOTS];
    logic        used_mem [TABLE_SLOTS];
    logic [AW-1:0] ord_mem [TABLE_SLOTS];

    hcat_pkg::state_t state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [63:0]   key_reg, key_next;
    logic [63:0]   amt_reg, amt_next;
    logic [9:0]    pos_reg, pos_next;
    logic [63:0]   z_reg, z_next;
    logic [63:0]   p_reg, p_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0]   ko_reg, ko_next;
    logic [63:0]   to_reg, to_next;
    logic [1:0]    st_reg, st_next;
    logic          ovalid_reg, ovalid_next;

    logic [63:0]   rd_key, rd_tot;
    logic          rd_used;
    logic [AW-1:0] rd_ord;
    logic          re_slot, re_ord;
    logic [AW-1:0] ra_slot;
    logic          we_slot, we_used, used_val, we_ord;
    logic [AW-1:0] wa_used;
    logic [63:0]   wd_tot;
    logic [63:0]   x;
    logic [63:0]   sum;

    always_ff @(posedge aclk) begin
        if (re_slot) begin
            rd_key  <= keys_mem[ra_slot];
            rd_tot  <= tots_mem[ra_slot];
            rd_used <= used_mem[ra_slot];
        end
        if (re_ord) begin
            rd_ord <= ord_mem[pos_reg[AW-1:0]];
        end
        if (we_slot) begin
            keys_mem[slot_reg] <= key_reg;
            tots_mem[slot_reg] <= wd_tot;
        end
        if (we_used) begin
            used_mem[wa_used] <= used_val;
        end
        if (we_ord) begin
            ord_mem[cnt_reg[AW-1:0]] <= slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= hcat_pkg::S_CLEAR;
            op_reg     <= hcat_pkg::OP_NONE;
            slot_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            slot_reg   <= slot_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
        key_reg <= key_next;
        amt_reg <= amt_next;
        pos_reg <= pos_next;
        z_reg   <= z_next;
        p_reg   <= p_next;
        n_reg   <= n_next;
        ko_reg  <= ko_next;
        to_reg  <= to_next;
        st_reg  <= st_next;
    end

    assign sum = rd_tot + amt_reg;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg; key_next = key_reg; amt_next = amt_reg; pos_next = pos_reg;
        z_next = z_reg; p_next = p_reg; slot_next = slot_reg; n_next = n_reg;
        cnt_next = cnt_reg; ko_next = ko_reg; to_next = to_reg; st_next = st_reg;
        ovalid_next = ovalid_reg;
        re_slot = 1'b0; re_ord = 1'b0; ra_slot = slot_reg;
        we_slot = 1'b0; we_used = 1'b0; used_val = 1'b0; we_ord = 1'b0;
        wa_used = slot_reg; wd_tot = amt_reg;
        x = z_reg;
        s_tready = 1'b0;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            hcat_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next  = s_tdata[1:0];
                    key_next = s_tdata[65:2];
                    amt_next = s_tdata[129:66];
                    pos_next = s_tdata[139:130];
                    z_next   = s_tdata[65:2] + hcat_pkg::MixAdd;
                    ko_next = '0; to_next = '0; st_next = hcat_pkg::ST_OK;
                    case (hcat_pkg::op_t'(s_tdata[1:0]))
                        hcat_pkg::OP_ADD:   state_next = hcat_pkg::S_H0;
                        hcat_pkg::OP_READ:  state_next = hcat_pkg::S_RWAIT;
                        hcat_pkg::OP_CLEAR: begin
                            state_next = hcat_pkg::S_CLEAR;
                            slot_next = '0;
                            cnt_next = '0;
                        end
                        default:            state_next = hcat_pkg::S_OUT;
                    endcase
                end
            end
            hcat_pkg::S_H0: begin
                x = z_reg ^ (z_reg >> 30);
                z_next = x;
                p_next = 64'(x[31:0]) * 64'(hcat_pkg::MixM1[31:0]);
                state_next = hcat_pkg::S_H1;
            end
            hcat_pkg::S_H1: begin
                p_next = p_reg + {32'(z_reg[31:0] * hcat_pkg::MixM1[63:32]), 32'd0};
                state_next = hcat_pkg::S_H2;
            end
            hcat_pkg::S_H2: begin
                x = p_reg + {32'(z_reg[63:32] * hcat_pkg::MixM1[31:0]), 32'd0};
                x = x ^ (x >> 27);
                z_next = x;
                p_next = 64'(x[31:0]) * 64'(hcat_pkg::MixM2[31:0]);
                state_next = hcat_pkg::S_H3;
            end
            hcat_pkg::S_H3: begin
                p_next = p_reg + {32'(z_reg[31:0] * hcat_pkg::MixM2[63:32]), 32'd0};
                state_next = hcat_pkg::S_H4;
            end
            hcat_pkg::S_H4: begin
                x = p_reg + {32'(z_reg[63:32] * hcat_pkg::MixM2[31:0]), 32'd0};
                x = x ^ (x >> 31);
                slot_next = x[AW-1:0];
                n_next = '0;
                state_next = hcat_pkg::S_PROBE;
            end
            hcat_pkg::S_PROBE: begin
                re_slot = 1'b1;
                state_next = hcat_pkg::S_PWAIT;
            end
            hcat_pkg::S_PWAIT: begin
                state_next = hcat_pkg::S_CHECK;
            end
            hcat_pkg::S_CHECK: begin
                ko_next = key_reg;
                if (!rd_used) begin
                    we_slot = 1'b1; we_used = 1'b1; used_val = 1'b1;
                    we_ord = (cnt_reg < CW'(TABLE_SLOTS));
                    cnt_next = cnt_reg + 1'b1;
                    to_next = amt_reg;
                    state_next = hcat_pkg::S_OUT;
                end else if (rd_key == key_reg) begin
                    we_slot = 1'b1; wd_tot = sum;
                    to_next = sum;
                    state_next = hcat_pkg::S_OUT;
                end else if (n_reg == CW'(TABLE_SLOTS - 1)) begin
                    st_next = hcat_pkg::ST_FULL;
                    state_next = hcat_pkg::S_OUT;
                end else begin
                    n_next = n_reg + 1'b1;
                    slot_next = slot_reg + 1'b1;
                    state_next = hcat_pkg::S_PROBE;
                end
            end
            hcat_pkg::S_RWAIT: begin
                if ({1'b0, pos_reg} >= 11'(cnt_reg) || 32'(pos_reg) >= TABLE_SLOTS) begin
                    st_next = hcat_pkg::ST_NOT_SET;
                    state_next = hcat_pkg::S_OUT;
                end else begin
                    re_ord = 1'b1;
                    state_next = hcat_pkg::S_RSLOT;
                end
            end
            hcat_pkg::S_RSLOT: begin
                re_slot = 1'b1; ra_slot = rd_ord;
                state_next = hcat_pkg::S_RDATA;
            end
            hcat_pkg::S_RDATA: begin
                ko_next = rd_key; to_next = rd_tot;
                state_next = hcat_pkg::S_OUT;
            end
            hcat_pkg::S_CLEAR: begin
                we_used = 1'b1; used_val = 1'b0;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == AW'(TABLE_SLOTS - 1)) begin
                    state_next = (op_reg == hcat_pkg::OP_CLEAR)
                                 ? hcat_pkg::S_OUT : hcat_pkg::S_IDLE;
                end
            end
            hcat_pkg::S_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    state_next = hcat_pkg::S_IDLE;
                end
            end
            default: state_next = hcat_pkg::S_IDLE;
        endcase
    end

    assign m_tvalid = ovalid_reg;

    logic [63:0] mk_reg, mt_reg;
    logic [CW-1:0] md_reg;
    logic [1:0] ms_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == hcat_pkg::S_OUT && (!ovalid_reg || m_tready)) begin
            mk_reg <= ko_reg; mt_reg <= to_reg; md_reg <= cnt_reg; ms_reg <= st_reg;
        end
    end

    assign m_tdata = {3'd0, ms_reg, 11'(md_reg), mt_reg, mk_reg};
endmodule

@@ tb/hcat_checker.sv @@
module hcat_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    output int           pending,
    output int           fail_count
);
    localparam int Slots = hcat_pkg::TableSlots;

    typedef struct packed {
        logic [63:0]       key;
        logic [63:0]       total;
        logic [10:0]       distinct;
        hcat_pkg::status_t status;
    } tally_t;

    logic [63:0] held_key   [Slots];
    logic [63:0] held_total [Slots];
    logic        held_used  [Slots];
    logic [9:0]  arrival    [Slots];
    logic [10:0] n_distinct;
    tally_t      tally_q[$];
    int          printed;

    initial begin
        for (int i = 0; i < Slots; i++) begin
            held_used[i] = 1'b0;
            held_key[i] = '0;
            held_total[i] = '0;
            arrival[i] = '0;
        end
        n_distinct = '0;
        fail_count = 0;
        pending = 0;
        printed = 0;
    end

    function automatic logic [63:0] splitmix(input logic [63:0] x);
        logic [63:0] z;
        z = x + 64'h9E3779B97F4A7C15;
        z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
        z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
        return z ^ (z >> 31);
    endfunction

    function automatic tally_t aggregate(input hcat_pkg::op_t op, input logic [63:0] key,
                                         input logic [63:0] amount, input logic [9:0] pos);
        tally_t r;
        int     slot;
        r = '{key: '0, total: '0, distinct: n_distinct, status: hcat_pkg::ST_OK};
        case (op)
            hcat_pkg::OP_ADD: begin
                slot = int'(splitmix(key) % Slots);
                r.key = key;
                r.status = hcat_pkg::ST_FULL;
                for (int n = 0; n < Slots; n++) begin
                    if (!held_used[slot]) begin
                        held_used[slot] = 1'b1;
                        held_key[slot] = key;
                        held_total[slot] = amount;
                        if (n_distinct < Slots) arrival[n_distinct] = slot[9:0];
                        n_distinct = n_distinct + 1'b1;
                        r.total = amount;
                        r.status = hcat_pkg::ST_OK;
                        break;
                    end
                    if (held_key[slot] == key) begin
                        held_total[slot] = held_total[slot] + amount;
                        r.total = held_total[slot];
                        r.status = hcat_pkg::ST_OK;
                        break;
                    end
                    slot = (slot + 1) % Slots;
                end
                r.distinct = n_distinct;
            end
            hcat_pkg::OP_READ: begin
                if (pos >= n_distinct) begin
                    r.status = hcat_pkg::ST_NOT_SET;
                end else begin
                    r.key = held_key[arrival[pos]];
                    r.total = held_total[arrival[pos]];
                end
            end
            hcat_pkg::OP_CLEAR: begin
                for (int i = 0; i < Slots; i++) held_used[i] = 1'b0;
                n_distinct = '0;
                r.distinct = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (printed < 30)
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        printed++;
        fail_count++;
    endtask

    always @(posedge aclk) begin
        tally_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tally_q = {tally_q, aggregate(hcat_pkg::op_t'(s_tdata[1:0]), s_tdata[65:2],
                                              s_tdata[129:66], s_tdata[139:130])};
            if (m_tvalid && m_tready) begin
                if (tally_q.size() == 0) begin
                    report("unexpected item", m_tdata[63:0], '0);
                end else begin
                    want = tally_q.pop_front();
                    if (m_tdata[63:0] !== want.key)
                        report("key_out", m_tdata[63:0], want.key);
                    if (m_tdata[127:64] !== want.total)
                        report("total_out", m_tdata[127:64], want.total);
                    if (m_tdata[138:128] !== want.distinct)
                        report("distinct_out", 64'(m_tdata[138:128]), 64'(want.distinct));
                    if (m_tdata[140:139] !== want.status)
                        report("status", 64'(m_tdata[140:139]), 64'(want.status));
                end
            end
            pending = tally_q.size();
        end
    end

endmodule

@@ tb/tb_hash_count_aggregation_table_top.sv @@
module tb_hash_count_aggregation_table_top;
    localparam int IdleLimit = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    int           pending;
    int           fail_count;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         hold_req = 1'b0;
    int           hold_left = 0;
    int           quiet = 0;
    logic [63:0]  key_pool[16];

    always #5 aclk = ~aclk;

    hash_count_aggregation_table_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    hcat_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 300;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet = 0;
        else quiet++;
        if (quiet >= IdleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(input hcat_pkg::op_t op, input logic [63:0] key,
                        input logic [63:0] amount, input logic [9:0] pos);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tdata = {4'b0, pos, amount, key, op};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int          pick;
        logic [63:0] k;
        pick = $urandom_range(99);
        k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : rand64();
        if (pick < 55) send(hcat_pkg::OP_ADD, k, rand64(), 10'($urandom));
        else if (pick < 85) send(hcat_pkg::OP_READ, rand64(), rand64(), 10'($urandom_range(20)));
        else if (pick < 92) send(hcat_pkg::OP_READ, rand64(), rand64(), 10'($urandom));
        else if (pick < 96) send(hcat_pkg::OP_NONE, rand64(), rand64(), 10'($urandom));
        else send(hcat_pkg::OP_CLEAR, rand64(), rand64(), 10'($urandom));
    endtask

    task automatic drain();
        while (pending != 0 || s_tvalid) @(negedge aclk);
    endtask

    initial begin
        for (int i = 0; i < 16; i++) key_pool[i] = rand64();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed
        hold_req = 1'b1;
        send(hcat_pkg::OP_READ, '0, '0, 10'd0);
        send(hcat_pkg::OP_NONE, '1, '1, '1);
        send(hcat_pkg::OP_ADD, '0, '0, '1);
        send(hcat_pkg::OP_ADD, '1, '1, '0);
        send(hcat_pkg::OP_ADD, '1, 64'd1, '0);
        send(hcat_pkg::OP_ADD, '0, '1, '0);
        send(hcat_pkg::OP_ADD, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, '0);
        send(hcat_pkg::OP_READ, '1, '1, 10'd0);
        send(hcat_pkg::OP_READ, '0, '0, 10'd1);
        send(hcat_pkg::OP_READ, '0, '0, 10'd2);
        send(hcat_pkg::OP_READ, '0, '0, 10'd3);
        send(hcat_pkg::OP_READ, '0, '0, 10'd1023);
        send(hcat_pkg::OP_CLEAR, '1, '1, '1);
        send(hcat_pkg::OP_READ, '0, '0, 10'd0);
        send(hcat_pkg::OP_ADD, '1, 64'd7, '0);
        send(hcat_pkg::OP_READ, '0, '0, 10'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 35 : 0;
            recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 35 : 0;
            for (int n = 0; n < 134; n++) random_item();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
